FILE: sv/power_format02_codec_defines.svh
// Assertion macros for the format 02 power codec.
// Used by the top level only; expects clk and rst in scope.
`ifndef POWER_FORMAT02_CODEC_DEFINES_SVH
`define POWER_FORMAT02_CODEC_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define PFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true outside reset.
`define PFC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: sv/pfc_pkg.sv
// Shared constants and arithmetic helpers for the format 02 power codec.
// No dependencies; used by pfc_enc, pfc_dec and power_format02_codec.
package pfc_pkg;

  // Conditional divide-by-ten stages in the encoder.
  localparam int DIV_STEPS = 6;
  // Total register stages from accepted word to result: input stage, the
  // divide stages, selection and two digit split stages in the encoder.
  localparam int PIPE_DEPTH = DIV_STEPS + 4;
  // Decoder arithmetic stages; the rest is delay padding.
  localparam int DEC_CORE = 3;
  localparam int DEC_PAD = PIPE_DEPTH - DEC_CORE;

  localparam logic [31:0] DIGIT_LIMIT = 32'd1000;
  localparam logic [9:0]  SAT_VALUE   = 10'd999;
  localparam logic [31:0] KW_LIMIT    = 32'd99900;
  localparam logic [2:0]  CODE_KW     = 3'd4;
  localparam logic [2:0]  CODE_DIV10  = 3'd7;

  // Exact floor(x / 10) for any 32-bit x.
  function automatic logic [31:0] div10(input logic [31:0] x);
    logic [63:0] p;
    p = {32'd0, x} * 64'h0000_0000_CCCC_CCCD;
    return {3'd0, p[63:35]};
  endfunction

  // Hundreds digit of v < 1000.
  function automatic logic [3:0] hundreds(input logic [9:0] v);
    logic [15:0] p;
    p = {6'd0, v} * 16'd41;
    return p[15:12];
  endfunction

  // Tens digit of r < 100.
  function automatic logic [3:0] tens(input logic [6:0] r);
    logic [14:0] p;
    p = {8'd0, r} * 15'd205;
    return p[14:11];
  endfunction

  // Decode scale 10^(6-code); code 7 is handled as a divide by ten.
  function automatic logic [19:0] pow10(input logic [2:0] code);
    logic [19:0] f;
    unique case (code)
      3'd0: f = 20'd1000000;
      3'd1: f = 20'd100000;
      3'd2: f = 20'd10000;
      3'd3: f = 20'd1000;
      3'd4: f = 20'd100;
      3'd5: f = 20'd10;
      3'd6: f = 20'd1;
      3'd7: f = 20'd1;
    endcase
    return f;
  endfunction

endpackage

FILE: sv/power_format02_codec.sv
// Top level of the format 02 power codec.
// Depends on pfc_pkg, pfc_enc, pfc_dec and power_format02_codec_defines.svh.
//
// Usage:
//   A word is accepted on a rising edge with start high and busy low. busy
//   is tied low: the block takes a new word on every cycle.
//   op = 0 decodes code_word into power_out (0.01 kW units, signed);
//   op = 1 encodes power_in into code_out. The unused result field is zero.
//   Each result shows on power_out/code_out for one cycle with done high;
//   encode and decode are padded to the same pipeline depth.
//   Throughput is one word per cycle; results leave in accept order.
//   Encoding runs through six conditional divide-by-ten stages (one
//   32x32 reciprocal multiply each), then digit selection and BCD split.
//   Decoding needs three stages of arithmetic and is padded with a delay
//   line so both paths have the same depth and never collide at the output.
//   Reset (rst, synchronous, active high) clears all valid bits; words in
//   flight are dropped. The receiver cannot stall the block, so no
//   backpressure storage exists: a result is lost if not taken on its cycle.
`include "power_format02_codec_defines.svh"

module power_format02_codec (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [15:0] code_word,
  input  logic [31:0] power_in,
  output logic        done,
  output logic [31:0] power_out,
  output logic [15:0] code_out
);

  logic        enc_vld;
  logic        dec_vld;
  logic [15:0] enc_word;
  logic [31:0] dec_pow;

  assign busy = 1'b0;

  pfc_enc u_enc (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (start && op),
    .power_in (power_in),
    .out_vld  (enc_vld),
    .code_out (enc_word)
  );

  pfc_dec u_dec (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (start && !op),
    .code_word (code_word),
    .out_vld   (dec_vld),
    .power_out (dec_pow)
  );

  // Same depth on both paths: at most one of them is valid per cycle.
  assign done      = enc_vld || dec_vld;
  assign power_out = dec_vld ? dec_pow : 32'd0;
  assign code_out  = enc_vld ? enc_word : 16'd0;

  `PFC_NEVER(a_no_collide, enc_vld && dec_vld, "encoder and decoder results collide")
  `PFC_ASSERT(a_latency, (start && !busy) |-> ##(pfc_pkg::PIPE_DEPTH) done, "no result for word")
  `PFC_ASSERT(a_no_orphan, done |-> $past(start, pfc_pkg::PIPE_DEPTH), "result without a word")

endmodule

FILE: sv/pfc_dec.sv
// Format 02 decoder pipeline: word to signed power, 0.01 kW units.
// Depends on pfc_pkg. Padded to the same depth as the encoder.
module pfc_dec (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic [15:0] code_word,
  output logic        out_vld,
  output logic [31:0] power_out
);

  // P1: digit value, exponent code, sign
  logic        p1_vld;
  logic [10:0] p1_d;
  logic [2:0]  p1_code;
  logic        p1_neg;
  // P2: scaled magnitude
  logic        p2_vld;
  logic [30:0] p2_mag;
  logic        p2_neg;
  // P3: signed result
  logic        p3_vld;
  logic [31:0] p3_pow;
  // delay line to match the encoder latency
  logic [pfc_pkg::DEC_PAD-1:0] pad_vld;
  logic [31:0] pad_pow [pfc_pkg::DEC_PAD];

  logic [10:0] d_next;
  logic [30:0] mag_next;
  logic [23:0] div_p;

  always_comb begin
    d_next = ({7'd0, code_word[11:8]} * 11'd100)
           + ({7'd0, code_word[7:4]} * 11'd10)
           + {7'd0, code_word[3:0]};
  end

  always_comb begin
    div_p = {13'd0, p1_d} * 24'd6554;   // floor(d/10) for d <= 1665
    if (p1_code == pfc_pkg::CODE_DIV10) begin
      mag_next = {23'd0, div_p[23:16]};
    end else begin
      mag_next = {20'd0, p1_d} * {11'd0, pfc_pkg::pow10(p1_code)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld  <= 1'b0;
      p2_vld  <= 1'b0;
      p3_vld  <= 1'b0;
      pad_vld <= '0;
    end else begin
      p1_vld  <= in_vld;
      p2_vld  <= p1_vld;
      p3_vld  <= p2_vld;
      pad_vld <= {pad_vld[pfc_pkg::DEC_PAD-2:0], p3_vld};
    end
  end

  always_ff @(posedge clk) begin
    p1_d    <= d_next;
    p1_code <= code_word[15:13];
    p1_neg  <= code_word[12];
    p2_mag  <= mag_next;
    p2_neg  <= p1_neg;
    p3_pow  <= p2_neg ? (32'd0 - {1'b0, p2_mag}) : {1'b0, p2_mag};
    pad_pow[0] <= p3_pow;
    for (int k = 1; k < pfc_pkg::DEC_PAD; k++) begin
      pad_pow[k] <= pad_pow[k-1];
    end
  end

  assign out_vld   = pad_vld[pfc_pkg::DEC_PAD-1];
  assign power_out = pad_pow[pfc_pkg::DEC_PAD-1];

endmodule

FILE: sv/pfc_enc.sv
// Format 02 encoder pipeline: signed power to format 02 word.
// Depends on pfc_pkg.
module pfc_enc (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic [31:0] power_in,
  output logic        out_vld,
  output logic [15:0] code_out
);

  typedef struct packed {
    logic [31:0] val;    // magnitude after the divisions so far
    logic [2:0]  n;      // divisions done
    logic        neg;
    logic        le;     // magnitude <= 99900
    logic        kw;     // exact whole kW, valid from the second stage on
    logic [9:0]  kwq;    // magnitude / 100
    logic [16:0] mag17;  // low bits of the magnitude for the kW check
  } enc_div_t;

  // E1: magnitude and sign
  logic        e1_vld;
  logic [31:0] e1_mag;
  logic        e1_neg;
  // divide-by-ten stages
  logic [pfc_pkg::DIV_STEPS-1:0] d_vld;
  enc_div_t d_stg  [pfc_pkg::DIV_STEPS];
  enc_div_t d_in   [pfc_pkg::DIV_STEPS];
  enc_div_t d_next [pfc_pkg::DIV_STEPS];
  // S: value and exponent code chosen
  logic        s_vld;
  logic [9:0]  s_val;
  logic [2:0]  s_code;
  logic        s_neg;
  // B1: hundreds digit and remainder
  logic        b1_vld;
  logic [3:0]  b1_h;
  logic [6:0]  b1_r;
  logic [2:0]  b1_code;
  logic        b1_neg;
  // B2: packed word
  logic        b2_vld;
  logic [15:0] b2_word;

  logic [34:0] kw_p;
  logic [9:0]  s_val_next;
  logic [2:0]  s_code_next;
  logic [6:0]  r_next;
  logic [3:0]  h_next;
  logic [3:0]  t_next;
  logic [3:0]  u_next;

  // first stage input: kW quotient via reciprocal, exact for values <= 99900
  always_comb begin
    kw_p = {18'd0, e1_mag[16:0]} * 35'd167773;
    d_in[0].val   = e1_mag;
    d_in[0].n     = 3'd0;
    d_in[0].neg   = e1_neg;
    d_in[0].le    = (e1_mag <= pfc_pkg::KW_LIMIT);
    d_in[0].kw    = 1'b0;
    d_in[0].kwq   = kw_p[33:24];
    d_in[0].mag17 = e1_mag[16:0];
    for (int k = 1; k < pfc_pkg::DIV_STEPS; k++) begin
      d_in[k] = d_stg[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < pfc_pkg::DIV_STEPS; k++) begin
      d_next[k] = d_in[k];
      if (d_in[k].val >= pfc_pkg::DIGIT_LIMIT) begin
        d_next[k].val = pfc_pkg::div10(d_in[k].val);
        d_next[k].n   = d_in[k].n + 3'd1;
      end
      if (k == 1) begin
        d_next[k].kw = d_in[k].le && (({7'd0, d_in[k].kwq} * 17'd100) == d_in[k].mag17);
      end
    end
  end

  // pick whole-kW form, normal form or saturation
  always_comb begin
    if (d_stg[pfc_pkg::DIV_STEPS-1].kw) begin
      s_val_next  = d_stg[pfc_pkg::DIV_STEPS-1].kwq;
      s_code_next = pfc_pkg::CODE_KW;
    end else begin
      s_code_next = ~(d_stg[pfc_pkg::DIV_STEPS-1].n + 3'd1);
      if (d_stg[pfc_pkg::DIV_STEPS-1].val >= pfc_pkg::DIGIT_LIMIT) begin
        s_val_next = pfc_pkg::SAT_VALUE;
      end else begin
        s_val_next = d_stg[pfc_pkg::DIV_STEPS-1].val[9:0];
      end
    end
  end

  always_comb begin
    h_next = pfc_pkg::hundreds(s_val);
    r_next = 7'(s_val - ({6'd0, h_next} * 10'd100));
    t_next = pfc_pkg::tens(b1_r);
    u_next = 4'(b1_r - ({3'd0, t_next} * 7'd10));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_vld <= 1'b0;
      d_vld  <= '0;
      s_vld  <= 1'b0;
      b1_vld <= 1'b0;
      b2_vld <= 1'b0;
    end else begin
      e1_vld <= in_vld;
      d_vld  <= {d_vld[pfc_pkg::DIV_STEPS-2:0], e1_vld};
      s_vld  <= d_vld[pfc_pkg::DIV_STEPS-1];
      b1_vld <= s_vld;
      b2_vld <= b1_vld;
    end
  end

  always_ff @(posedge clk) begin
    e1_mag <= power_in[31] ? (32'd0 - power_in) : power_in;
    e1_neg <= power_in[31];
    for (int k = 0; k < pfc_pkg::DIV_STEPS; k++) begin
      d_stg[k] <= d_next[k];
    end
    s_val   <= s_val_next;
    s_code  <= s_code_next;
    s_neg   <= d_stg[pfc_pkg::DIV_STEPS-1].neg;
    b1_h    <= h_next;
    b1_r    <= r_next;
    b1_code <= s_code;
    b1_neg  <= s_neg;
    b2_word <= {b1_code, b1_neg, b1_h, t_next, u_next};
  end

  assign out_vld  = b2_vld;
  assign code_out = b2_word;

endmodule
